// ===== rtl/pofp_pkg.sv =====
// Shared types and constants for the pulse oximeter frame parser.
// No dependencies; used by the decoder, the top level and the checker.
package pofp_pkg;

  // Data bytes after the header, and the index width of the byte store.
  localparam int unsigned DataLen = 4;
  localparam int unsigned PosW    = 2;

  localparam int unsigned SyncBit      = 7;
  localparam int unsigned SensorErrBit = 4;
  localparam int unsigned PulseHiBit   = 6;

  localparam logic [6:0] Spo2Invalid  = 7'h7F;
  localparam logic [7:0] PulseInvalid = 8'hFF;

  localparam logic [PosW-1:0] LastPos = PosW'(DataLen - 1);

  typedef struct packed {
    logic [6:0] spo2_percent;
    logic [7:0] pulse_rate;
    logic       sensor_error;
    logic       frame_bad;
  } result_t;

endpackage

// ===== rtl/pofp_decode.sv =====
// Combinational decode of the four data bytes of one frame into a result.
// Depends on pofp_pkg for the result type and the invalid codes.
module pofp_decode (
  input  logic [7:0]       byte1_i,
  input  logic [7:0]       byte2_i,
  input  logic [7:0]       byte3_i,
  input  logic [7:0]       byte4_i,
  output pofp_pkg::result_t result_o
);

  logic bad;
  logic serr;

  // A data byte with the sync bit set means the frame lost alignment.
  assign bad  = byte1_i[pofp_pkg::SyncBit] | byte2_i[pofp_pkg::SyncBit] |
                byte3_i[pofp_pkg::SyncBit] | byte4_i[pofp_pkg::SyncBit];
  assign serr = bad | byte2_i[pofp_pkg::SensorErrBit];

  always_comb begin
    result_o.frame_bad    = bad;
    result_o.sensor_error = serr;
    if (serr) begin
      result_o.spo2_percent = pofp_pkg::Spo2Invalid;
      result_o.pulse_rate   = pofp_pkg::PulseInvalid;
    end else begin
      result_o.spo2_percent = byte4_i[6:0];
      result_o.pulse_rate   = {byte2_i[pofp_pkg::PulseHiBit], byte3_i[6:0]};
    end
  end

endmodule

// ===== rtl/pulse_oximeter_frame_parser.sv =====
// Top level of the pulse oximeter frame parser: framing state, byte store,
// counter and output register. Depends on pofp_pkg and pofp_decode.
//
// Usage: received serial bytes enter one beat at a time on the input channel
// (in_valid_i, in_stall_o, rx_byte_i). While hunting, bytes without bit 7
// are dropped; the first byte with bit 7 set is the header. The following
// four bytes are data, whatever their value, and each bumps a wrapping
// 16-bit byte counter. The fourth data byte produces one result beat on the
// output channel (out_valid_o, out_stall_i and the decoded fields); all other
// bytes produce nothing.
// Throughput is one byte per cycle while in_stall_o is low. The result for the
// last data byte appears on the outputs the cycle after that byte is taken,
// straight from the output register.
// When the receiver stalls a waiting result, the result holds and in_stall_o
// rises, so only the output register sets the pace; bytes keep flowing
// whenever the output register is empty or being emptied.
// Reset (rst_ni low, asynchronous) returns the parser to hunting, clears the
// frame position and the byte counter and empties the output register.
module pulse_oximeter_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  spo2_percent_o,
  output logic [7:0]  pulse_rate_o,
  output logic        sensor_error_o,
  output logic        frame_bad_o,
  output logic [15:0] byte_count_o
);

  logic                          hunting_q, hunting_d;
  logic [pofp_pkg::PosW-1:0]     pos_q, pos_d;
  logic [15:0]                   count_q, count_d;
  logic [7:0]                    data_q [pofp_pkg::DataLen-1];
  logic                          out_valid_q, out_valid_d;
  pofp_pkg::result_t             result_q, result_d;
  logic [15:0]                   out_count_q;

  logic out_free;
  logic accept;
  logic store_byte;
  logic frame_done;

  // The output register can take a new result when empty or being drained.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !out_free;
  assign accept     = in_valid_i && out_free;

  // Inside a frame, the last data byte completes it; earlier ones are kept.
  assign frame_done = accept && !hunting_q && (pos_q == pofp_pkg::LastPos);
  assign store_byte = accept && !hunting_q && (pos_q != pofp_pkg::LastPos);

  // The fourth data byte is decoded live, next to the three stored ones.
  pofp_decode u_decode (
    .byte1_i  (data_q[0]),
    .byte2_i  (data_q[1]),
    .byte3_i  (data_q[2]),
    .byte4_i  (rx_byte_i),
    .result_o (result_d)
  );

  always_comb begin
    hunting_d = hunting_q;
    pos_d     = pos_q;
    count_d   = count_q;
    if (accept) begin
      if (hunting_q) begin
        // Only a byte with the sync bit opens a frame.
        if (rx_byte_i[pofp_pkg::SyncBit]) begin
          hunting_d = 1'b0;
          pos_d     = '0;
        end
      end else begin
        count_d = count_q + 16'd1;
        if (pos_q == pofp_pkg::LastPos) begin
          hunting_d = 1'b1;
          pos_d     = '0;
        end else begin
          pos_d = pos_q + pofp_pkg::PosW'(1);
        end
      end
    end
  end

  always_comb begin
    if (out_free) begin
      out_valid_d = frame_done;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hunting_q   <= 1'b1;
      pos_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      hunting_q   <= hunting_d;
      pos_q       <= pos_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: byte store and result, no reset needed.
  always_ff @(posedge clk_i) begin
    if (store_byte) begin
      data_q[pos_q] <= rx_byte_i;
    end
    if (frame_done) begin
      result_q    <= result_d;
      out_count_q <= count_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign spo2_percent_o = result_q.spo2_percent;
  assign pulse_rate_o   = result_q.pulse_rate;
  assign sensor_error_o = result_q.sensor_error;
  assign frame_bad_o    = result_q.frame_bad;
  assign byte_count_o   = out_count_q;

endmodule

// ===== rtl/pofp_checker.sv =====
// Port-level assertions for the pulse oximeter frame parser, with their bind.
// Depends on pofp_pkg for the invalid codes.
module pofp_assertions (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [6:0]  spo2_percent_o,
  input logic [7:0]  pulse_rate_o,
  input logic        sensor_error_o,
  input logic        frame_bad_o
);

  // A result that is stalled stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result beat was dropped");

  // A bad frame always reports a sensor error.
  a_bad_implies_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_bad_o |-> sensor_error_o)
    else $error("bad frame without error flag");

  // Any error forces both measurement fields to their invalid codes.
  a_err_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sensor_error_o |->
      (spo2_percent_o == pofp_pkg::Spo2Invalid) &&
      (pulse_rate_o == pofp_pkg::PulseInvalid))
    else $error("error result carries measurement values");

  // The input side is held back only while a result waits on a stall.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a pending result");

  // A new result only follows an accepted byte.
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_valid_o && out_stall_i) |->
      $past(in_valid_i && !in_stall_o))
    else $error("result appeared without an input beat");

endmodule

bind pulse_oximeter_frame_parser pofp_assertions u_pofp_assertions (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .spo2_percent_o (spo2_percent_o),
  .pulse_rate_o   (pulse_rate_o),
  .sensor_error_o (sensor_error_o),
  .frame_bad_o    (frame_bad_o)
);

// ===== sim/pofp_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the pulse oximeter frame parser: tracks framing on the byte
// channel, predicts each decoded reading and compares it with the result beats.
// Depends on pofp_pkg for the result fields and the decode constants.
module pofp_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [6:0]  spo2_percent_i,
  input  logic [7:0]  pulse_rate_i,
  input  logic        sensor_error_i,
  input  logic        frame_bad_i,
  input  logic [15:0] byte_count_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    pofp_pkg::result_t fields;
    logic [15:0]       count;
  } reading_t;

  reading_t    reading_q[$];
  logic        hunting;
  logic [2:0]  position;
  logic [7:0]  frame_store [0:pofp_pkg::DataLen];
  logic [15:0] frame_byte_count;
  int unsigned mismatches;

  function automatic reading_t decode_reading(input logic [7:0] b1, input logic [7:0] b2,
                                              input logic [7:0] b3, input logic [7:0] b4,
                                              input logic [15:0] count);
    reading_t r;
    r.count              = count;
    r.fields.frame_bad   = b1[pofp_pkg::SyncBit] | b2[pofp_pkg::SyncBit] |
                           b3[pofp_pkg::SyncBit] | b4[pofp_pkg::SyncBit];
    r.fields.sensor_error = r.fields.frame_bad | b2[pofp_pkg::SensorErrBit];
    if (r.fields.sensor_error) begin
      r.fields.spo2_percent = pofp_pkg::Spo2Invalid;
      r.fields.pulse_rate   = pofp_pkg::PulseInvalid;
    end else begin
      r.fields.spo2_percent = b4[6:0];
      r.fields.pulse_rate   = {b2[pofp_pkg::PulseHiBit], b3[6:0]};
    end
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    reading_t want;
    if (!rst_ni) begin
      hunting          = 1'b1;
      position         = '0;
      frame_byte_count = '0;
      mismatches       = 0;
      for (int i = 0; i <= pofp_pkg::DataLen; i++) frame_store[i] = '0;
      reading_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (reading_q.size() == 0) begin
          $error("result beat arrived with no reading pending");
          mismatches++;
        end else begin
          want = reading_q.pop_front();
          compare_field("spo2_percent", 16'(want.fields.spo2_percent), 16'(spo2_percent_i));
          compare_field("pulse_rate", 16'(want.fields.pulse_rate), 16'(pulse_rate_i));
          compare_field("sensor_error", 16'(want.fields.sensor_error), 16'(sensor_error_i));
          compare_field("frame_bad", 16'(want.fields.frame_bad), 16'(frame_bad_i));
          compare_field("byte_count", want.count, byte_count_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (hunting) begin
          if (rx_byte_i[pofp_pkg::SyncBit]) begin
            hunting        = 1'b0;
            position       = '0;
            frame_store[0] = rx_byte_i;
          end
        end else begin
          // A byte inside a frame is data even with bit 7 set.
          position         = position + 3'd1;
          frame_byte_count = frame_byte_count + 16'd1;
          if (position <= pofp_pkg::DataLen) frame_store[position] = rx_byte_i;
          if (position >= pofp_pkg::DataLen) begin
            hunting  = 1'b1;
            position = '0;
            reading_q.push_back(decode_reading(frame_store[1], frame_store[2],
                                               frame_store[3], frame_store[4],
                                               frame_byte_count));
          end
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= unsigned'(reading_q.size());
  end

endmodule

// ===== sim/tb_pulse_oximeter_frame_parser.sv =====
`timescale 1ns / 100ps
// Top of the frame parser testbench: clock, reset, byte and stall stimulus and
// the verdict. Depends on pulse_oximeter_frame_parser and pofp_checker.
module tb_pulse_oximeter_frame_parser;

  // All block inputs start at known values; after that they only change by
  // nonblocking assignment at the rising edge.
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [6:0]  spo2_percent;
  logic [7:0]  pulse_rate;
  logic        sensor_error;
  logic        frame_bad;
  logic [15:0] byte_count;
  int unsigned fail_count;
  int unsigned pending;

  // Percent chance of starting an idle burst after a byte beat, and of the
  // receiver starting a stall burst on a given cycle.
  int unsigned in_idle_pct  = 0;
  int unsigned out_idle_pct = 0;
  int unsigned stall_left   = 0;

  // Stimulus bookkeeping: byte beats sent.
  int unsigned sent_beats = 0;

  always #5 clk = ~clk;

  pulse_oximeter_frame_parser u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .spo2_percent_o (spo2_percent),
    .pulse_rate_o   (pulse_rate),
    .sensor_error_o (sensor_error),
    .frame_bad_o    (frame_bad),
    .byte_count_o   (byte_count)
  );

  pofp_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .rx_byte_i      (rx_byte),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .spo2_percent_i (spo2_percent),
    .pulse_rate_i   (pulse_rate),
    .sensor_error_i (sensor_error),
    .frame_bad_i    (frame_bad),
    .byte_count_i   (byte_count),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Receiver side. Stall comes in bursts; a burst that has started always runs
  // out, even when the stall rate drops to zero.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(99) < out_idle_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(10);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Puts one byte on the channel and returns at the edge where it is taken.
  // Valid stays high into the next beat unless an idle burst follows, so a
  // valid that stays high is never lowered and raised in the same step.
  task automatic send_byte(input logic [7:0] value);
    in_valid <= 1'b1;
    rx_byte  <= value;
    do @(posedge clk); while (in_stall);
    sent_beats++;
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // Sends a header and four data bytes given explicitly.
  task automatic send_frame(input logic [7:0] header, input logic [7:0] b1,
                            input logic [7:0] b2, input logic [7:0] b3,
                            input logic [7:0] b4);
    send_byte(header);
    send_byte(b1);
    send_byte(b2);
    send_byte(b3);
    send_byte(b4);
  endtask

  // A well-formed frame with random content. Data bytes usually keep bit 7
  // clear so most frames decode; now and then one carries bit 7 and the frame
  // comes back bad. The sensor error bit is set on about a quarter of frames
  // so that the real readings are seen often.
  task automatic send_random_frame();
    logic [7:0] d [1:4];
    for (int i = 1; i <= 4; i++) begin
      d[i] = 8'($urandom_range(127));
      if ($urandom_range(15) == 0) d[i][7] = 1'b1;
    end
    d[2][4] = ($urandom_range(3) == 0);
    send_frame(8'h80 | 8'($urandom_range(127)), d[1], d[2], d[3], d[4]);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats. Bytes without bit 7 are dropped while hunting.
    send_byte(8'h00);
    send_byte(8'h7F);
    // All-zero frame behind the smallest header.
    send_frame(8'h80, 8'h00, 8'h00, 8'h00, 8'h00);
    // Largest values: pulse high bit set with the low seven bits all ones,
    // and SpO2 at its top, behind the largest header.
    send_frame(8'hFF, 8'h7F, 8'h4F, 8'h7F, 8'h7F);
    // Sensor error on an otherwise good frame hides the readings.
    send_frame(8'h80, 8'h00, 8'h10, 8'h05, 8'h60);
    // Bit 7 in the waveform byte marks the frame bad.
    send_frame(8'h80, 8'h80, 8'h00, 8'h00, 8'h00);
    // A header-like byte in the last data slot is data, and the frame is bad.
    send_frame(8'h81, 8'h00, 8'h00, 8'h00, 8'hFF);

    // Random part: mostly well-formed frames, with noise between them. A
    // noise byte with bit 7 set starts a frame early, which breaks the
    // alignment of the frame that follows. Idle and stall rates are chosen
    // again from time to time, so some stretches run with no idling at all.
    in_idle_pct  = 15;
    out_idle_pct = 15;
    while (sent_beats < 1800) begin
      if ($urandom_range(19) == 0) begin
        in_idle_pct  = $urandom_range(2) * 25;
        out_idle_pct = $urandom_range(2) * 25;
      end
      if ($urandom_range(9) < 3) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(127)));
      end
      if ($urandom_range(19) == 0) send_byte(8'($urandom_range(255)));
      send_random_frame();
    end

    // Last part: frames back to back with no idling on either side.
    in_idle_pct  = 0;
    out_idle_pct = 0;
    repeat (40) send_random_frame();

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // A further wait lets any stray result beat show up.
    repeat (16) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== pulse_oximeter_frame_parser.f =====
rtl/pofp_pkg.sv
rtl/pofp_decode.sv
rtl/pulse_oximeter_frame_parser.sv
rtl/pofp_checker.sv
sim/pofp_checker.sv
sim/tb_pulse_oximeter_frame_parser.sv
